/* hw/rtl/rrts_pkg.sv */
// Package for the round-robin task scheduler.
// Holds op codes, slot state codes, sequencer states, status codes and
// fixed field widths. No dependencies.
`default_nettype none

package rrts_pkg;

  localparam int OP_W    = 3;   // op field
  localparam int TPID_W  = 8;   // target_pid field
  localparam int CNT_W   = 32;  // sleep_count field
  localparam int PID_W   = 4;   // result_pid / running_pid fields
  localparam int SST_W   = 3;   // stored slot state

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_FORK    = 3'd2,
    OP_SLEEP   = 3'd3,
    OP_EXIT    = 3'd4,
    OP_SUSPEND = 3'd5,
    OP_RESUME  = 3'd6
  } op_t;

  typedef enum logic [SST_W-1:0] {
    ST_UNUSED    = 3'd0,
    ST_READY     = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_BLOCKED   = 3'd3,
    ST_DEAD      = 3'd4,
    ST_SUSPENDED = 3'd5
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_POKE,
    S_DONE
  } fsm_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/round_robin_task_scheduler.sv */
// Round-robin task scheduler top level: slot table memory, walk sequencer,
// shared sleep decrementer and result register. Depends on rrts_pkg.
//
// Usage: one item on the in_ channel (op, target_pid, sleep_count) gives one
// item on the out_ channel (status, result_pid, running_valid, running_pid).
// Both channels are valid/ready; an item moves when valid and ready are high.
// The slot table lives in a memory with one write and one registered read
// port; a sequencer walks it one slot per cycle through a single shared
// decrementer/compare path.
// Work per item, TASK_SLOTS = N:
//   tick, create, fork: full walk of the table (N slots)
//   suspend, resume:    one slot read and written back
//   sleep, exit:        one direct write
//   rejected ops:       no table access, straight to the done state
// in_ready is high only while the sequencer is idle, so one item is in work
// at a time. A finished result sits in the output register while the next
// item is taken; if the receiver stalls, the following result waits in the
// done state.
// Reset (rst_n low, synchronous) marks all slots unused via per-slot valid
// bits, drops the current task and empties the output register; no clearing pass.
`default_nettype none

module round_robin_task_scheduler #(
  parameter int TASK_SLOTS = 16,
  parameter int SLEEP_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rrts_pkg::OP_W-1:0]   in_op,
  input  wire logic [rrts_pkg::TPID_W-1:0] in_target_pid,
  input  wire logic [rrts_pkg::CNT_W-1:0]  in_sleep_count,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic [rrts_pkg::PID_W-1:0]       out_result_pid,
  output logic                             out_running_valid,
  output logic [rrts_pkg::PID_W-1:0]       out_running_pid
);

  import rrts_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int LEFT_W = $clog2(TASK_SLOTS + 1);
  localparam int ENT_W  = SST_W + SLEEP_BITS;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
    if (a == SLOT_W'(TASK_SLOTS - 1)) return '0;
    else                              return a + 1'b1;
  endfunction

  // ---- registers ----
  fsm_t                  fsm_r, fsm_nxt;
  op_t                   op_r, op_nxt;
  logic [SLEEP_BITS-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]     iss_addr_r, iss_addr_nxt;
  logic [LEFT_W-1:0]     iss_left_r, iss_left_nxt;
  logic                  proc_v_r, proc_v_nxt;
  logic [SLOT_W-1:0]     proc_addr_r, proc_addr_nxt;
  logic                  found_r, found_nxt;
  logic [SLOT_W-1:0]     pick_r, pick_nxt;
  logic                  err_r, err_nxt;
  logic                  have_cur_r, have_cur_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [PID_W-1:0]      out_made_r, out_made_nxt;
  logic                  out_run_v_r, out_run_v_nxt;
  logic [PID_W-1:0]      out_run_pid_r, out_run_pid_nxt;

  // slot table: {state, sleep} per slot, valid bit marks written entries
  logic [ENT_W-1:0]      mem [TASK_SLOTS];
  logic [ENT_W-1:0]      rdata_r;
  logic [TASK_SLOTS-1:0] vld_r;
  logic                  rvld_r;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_wa;
  logic [ENT_W-1:0]      mem_wd;

  // ---- accept decode ----
  op_t               in_op_e;
  logic              acc;
  logic              go_walk, go_poke;
  logic              pid_bad;
  logic [SLOT_W-1:0] walk_start;
  logic [LEFT_W-1:0] walk_len;
  logic              out_free;

  assign in_op_e  = op_t'(in_op);
  assign acc      = in_valid && in_ready;
  assign pid_bad  = (32'(in_target_pid) >= TASK_SLOTS);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    go_walk    = 1'b0;
    go_poke    = 1'b0;
    walk_start = '0;
    walk_len   = LEFT_W'(TASK_SLOTS);
    unique case (in_op_e) inside
      OP_TICK: begin
        go_walk    = 1'b1;
        walk_start = slot_inc(have_cur_r ? cur_r : '0);
      end
      OP_CREATE: go_walk = 1'b1;
      OP_FORK:   go_walk = have_cur_r;
      OP_SLEEP, OP_EXIT: go_poke = have_cur_r;
      OP_SUSPEND, OP_RESUME: begin
        go_walk    = !pid_bad;
        walk_start = in_target_pid[SLOT_W-1:0];
        walk_len   = LEFT_W'(1);
      end
      default: ;
    endcase
  end

  // ---- walk datapath: one slot per cycle ----
  logic                  issuing;
  slot_st_t              st;
  logic [SLEEP_BITS-1:0] sl;
  slot_st_t              tick_st;
  logic [SLEEP_BITS-1:0] tick_sl;

  assign issuing = (iss_left_r != '0);
  assign st      = rvld_r ? slot_st_t'(rdata_r[ENT_W-1 -: SST_W]) : ST_UNUSED;
  assign sl      = rdata_r[SLEEP_BITS-1:0];

  // tick update of one slot: countdown, free, running back to ready
  always_comb begin
    tick_st = st;
    tick_sl = sl;
    case (st)
      ST_BLOCKED: begin
        tick_sl = (sl != '0) ? sl - 1'b1 : '0;
        if (tick_sl == '0) tick_st = ST_READY;
      end
      ST_DEAD: tick_st = ST_UNUSED;
      ST_RUNNING: begin
        if (have_cur_r && proc_addr_r == cur_r) tick_st = ST_READY;
      end
      default: ;
    endcase
  end

  // ---- next state ----
  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      S_IDLE: begin
        if (acc) begin
          if (go_walk)      fsm_nxt = S_WALK;
          else if (go_poke) fsm_nxt = S_POKE;
          else              fsm_nxt = S_DONE;
        end
      end
      S_WALK:  if (!issuing && !proc_v_r) fsm_nxt = S_DONE;
      S_POKE:  fsm_nxt = S_DONE;
      S_DONE:  if (out_free) fsm_nxt = S_IDLE;
      default: fsm_nxt = S_IDLE;
    endcase
  end

  // ---- datapath and outputs ----
  always_comb begin
    op_nxt          = op_r;
    cnt_nxt         = cnt_r;
    iss_addr_nxt    = iss_addr_r;
    iss_left_nxt    = iss_left_r;
    proc_v_nxt      = 1'b0;
    proc_addr_nxt   = iss_addr_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    err_nxt         = err_r;
    have_cur_nxt    = have_cur_r;
    cur_nxt         = cur_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_made_nxt    = out_made_r;
    out_run_v_nxt   = out_run_v_r;
    out_run_pid_nxt = out_run_pid_r;
    mem_we          = 1'b0;
    mem_wa          = proc_addr_r;
    mem_wd          = {ST_UNUSED, {SLEEP_BITS{1'b0}}};

    unique case (fsm_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt       = in_op_e;
          cnt_nxt      = in_sleep_count[SLEEP_BITS-1:0];
          iss_addr_nxt = walk_start;
          iss_left_nxt = go_walk ? walk_len : '0;
          found_nxt    = 1'b0;
          pick_nxt     = '0;
          err_nxt      = !(go_walk || go_poke);
        end
      end

      S_WALK: begin
        if (issuing) begin
          iss_left_nxt = iss_left_r - 1'b1;
          iss_addr_nxt = slot_inc(iss_addr_r);
          proc_v_nxt   = 1'b1;
        end
        if (proc_v_r) begin
          case (op_r) inside
            OP_TICK: begin
              mem_we = 1'b1;
              if (!found_r && tick_st == ST_READY) begin
                found_nxt = 1'b1;
                pick_nxt  = proc_addr_r;
                mem_wd    = {ST_RUNNING, tick_sl};
              end else begin
                mem_wd    = {tick_st, tick_sl};
              end
            end
            OP_CREATE, OP_FORK: begin
              if (!found_r && st == ST_UNUSED) begin
                found_nxt = 1'b1;
                pick_nxt  = proc_addr_r;
                mem_we    = 1'b1;
                mem_wd    = {ST_READY, {SLEEP_BITS{1'b0}}};
              end
            end
            OP_SUSPEND: begin
              if (st == ST_UNUSED) begin
                err_nxt = 1'b1;
              end else begin
                mem_we = 1'b1;
                mem_wd = {ST_SUSPENDED, sl};
              end
            end
            OP_RESUME: begin
              if (st != ST_SUSPENDED) begin
                err_nxt = 1'b1;
              end else begin
                mem_we = 1'b1;
                mem_wd = {ST_READY, sl};
              end
            end
            default: ;
          endcase
        end
      end

      S_POKE: begin
        mem_we = 1'b1;
        mem_wa = cur_r;
        if (op_r == OP_SLEEP) mem_wd = {ST_BLOCKED, cnt_r};
        else                  mem_wd = {ST_DEAD, {SLEEP_BITS{1'b0}}};
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (op_r == OP_TICK) begin
            have_cur_nxt = found_r;
            cur_nxt      = found_r ? pick_r : '0;
          end
          if ((op_r inside {OP_CREATE, OP_FORK}) && !err_r) begin
            out_status_nxt = found_r ? STATUS_OK : STATUS_ERR;
            out_made_nxt   = found_r ? PID_W'(pick_r) : '0;
          end else begin
            out_status_nxt = err_r ? STATUS_ERR : STATUS_OK;
            out_made_nxt   = '0;
          end
          out_run_v_nxt   = have_cur_nxt;
          out_run_pid_nxt = PID_W'(cur_nxt);
        end
      end

      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      iss_left_r  <= '0;
      proc_v_r    <= 1'b0;
      have_cur_r  <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rvld_r      <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      iss_left_r  <= iss_left_nxt;
      proc_v_r    <= proc_v_nxt;
      have_cur_r  <= have_cur_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= vld_r[iss_addr_r];
      if (mem_we) vld_r[mem_wa] <= 1'b1;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    cnt_r         <= cnt_nxt;
    iss_addr_r    <= iss_addr_nxt;
    proc_addr_r   <= proc_addr_nxt;
    found_r       <= found_nxt;
    pick_r        <= pick_nxt;
    err_r         <= err_nxt;
    out_status_r  <= out_status_nxt;
    out_made_r    <= out_made_nxt;
    out_run_v_r   <= out_run_v_nxt;
    out_run_pid_r <= out_run_pid_nxt;
  end

  // ---- slot table memory ----
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[iss_addr_r];
  end

  assign in_ready          = (fsm_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_pid    = out_made_r;
  assign out_running_valid = out_run_v_r;
  assign out_running_pid   = out_run_pid_r;

`ifndef SYNTHESIS
  a_made_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_ERR |-> out_result_pid == '0)
    else $error("slot reported on an error result");

  a_idle_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_pid == '0)
    else $error("running pid not zero while idle");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_walk_drained: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_r == S_DONE |-> !proc_v_r && iss_left_r == '0)
    else $error("walk left slots unprocessed");

  a_idle_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !have_cur_r |-> cur_r == '0)
    else $error("current slot kept while idle");
`endif

endmodule

`default_nettype wire

/* tb/tb_round_robin_task_scheduler.sv */
// Testbench for the round-robin task scheduler: directed and random op items
// checked against a cycle-free scheduler predictor. Depends on rrts_pkg and
// round_robin_task_scheduler.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int SLOTS = 16;
  localparam int SLEEP_W = 32;
  localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;  // no such op, always rejected
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic             status;
    logic [PID_W-1:0] made_pid;
    logic             run_valid;
    logic [PID_W-1:0] run_pid;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = '0;
  logic [TPID_W-1:0] in_target_pid = '0;
  logic [CNT_W-1:0] in_sleep_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [PID_W-1:0] out_result_pid;
  logic out_running_valid;
  logic [PID_W-1:0] out_running_pid;

  round_robin_task_scheduler #(
    .TASK_SLOTS(SLOTS),
    .SLEEP_BITS(SLEEP_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_target_pid(in_target_pid),
    .in_sleep_count(in_sleep_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_result_pid(out_result_pid),
    .out_running_valid(out_running_valid),
    .out_running_pid(out_running_pid)
  );

  always #1 clk = ~clk;

  // Predicted scheduler state
  slot_st_t task_st [SLOTS];
  logic [SLEEP_W-1:0] task_sleep [SLOTS];
  logic have_cur = 1'b0;
  logic [PID_W-1:0] cur_slot = '0;

  outcome_t awaited_outcomes [$];
  int mismatches = 0;
  int cycle_count = 0;
  logic gaps_on = 1'b0;       // sender gaps and receiver stalls enabled
  int burst_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      task_st[s] = ST_UNUSED;
      task_sleep[s] = '0;
    end
  end

  // Applies one op to the predicted table and returns the result it gives.
  function automatic outcome_t advance_scheduler(input logic [OP_W-1:0] op,
                                                 input logic [TPID_W-1:0] pid,
                                                 input logic [CNT_W-1:0] count);
    outcome_t res;
    int slot;
    int pick;
    int i;
    bit found;
    res = '0;
    res.status = STATUS_OK;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        // countdown of sleepers, freeing of dead slots
        for (slot = 0; slot < SLOTS; slot++) begin
          if (task_st[slot] == ST_BLOCKED) begin
            if (task_sleep[slot] != '0) task_sleep[slot] = task_sleep[slot] - 1'b1;
            if (task_sleep[slot] == '0) task_st[slot] = ST_READY;
          end else if (task_st[slot] == ST_DEAD) begin
            task_st[slot] = ST_UNUSED;
          end
        end
        if (have_cur && task_st[cur_slot] == ST_RUNNING) task_st[cur_slot] = ST_READY;
        // scan starts after the current slot, start slot checked last
        pick = have_cur ? int'(cur_slot) : 0;
        for (i = 0; i < SLOTS && !found; i++) begin
          pick = (pick + 1) % SLOTS;
          if (task_st[pick] == ST_READY) begin
            found = 1'b1;
            have_cur = 1'b1;
            cur_slot = pick[PID_W-1:0];
            task_st[pick] = ST_RUNNING;
          end
        end
        if (!found) begin
          have_cur = 1'b0;
          cur_slot = '0;
        end
      end
      OP_CREATE, OP_FORK: begin
        if (op == OP_FORK && !have_cur) begin
          res.status = STATUS_ERR;
        end else begin
          for (slot = 0; slot < SLOTS && !found; slot++) begin
            if (task_st[slot] == ST_UNUSED) begin
              found = 1'b1;
              task_sleep[slot] = '0;
              task_st[slot] = ST_READY;
              res.made_pid = slot[PID_W-1:0];
            end
          end
          if (!found) res.status = STATUS_ERR;
        end
      end
      OP_SLEEP: begin
        if (have_cur) begin
          task_sleep[cur_slot] = count[SLEEP_W-1:0];
          task_st[cur_slot] = ST_BLOCKED;
        end else begin
          res.status = STATUS_ERR;
        end
      end
      OP_EXIT: begin
        if (have_cur) task_st[cur_slot] = ST_DEAD;
        else res.status = STATUS_ERR;
      end
      OP_SUSPEND: begin
        if (pid >= SLOTS || task_st[pid] == ST_UNUSED) res.status = STATUS_ERR;
        else task_st[pid] = ST_SUSPENDED;
      end
      OP_RESUME: begin
        if (pid >= SLOTS || task_st[pid] != ST_SUSPENDED) res.status = STATUS_ERR;
        else task_st[pid] = ST_READY;
      end
      default: res.status = STATUS_ERR;
    endcase
    res.run_valid = have_cur;
    res.run_pid = have_cur ? cur_slot : '0;
    return res;
  endfunction

  // Sends one item; called at a rising edge, returns at the edge that accepts it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TPID_W-1:0] pid,
                           input logic [CNT_W-1:0] count);
    int gap;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 24);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_op <= op;
    in_target_pid <= pid;
    in_sleep_count <= count;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    awaited_outcomes.push_back(advance_scheduler(op, pid, count));
  endtask

  // Suspend/resume target: mostly a slot where the op can succeed.
  function automatic logic [TPID_W-1:0] pick_target(input bit want_suspended);
    int start;
    int s;
    int k;
    if ($urandom_range(0, 9) == 0) return TPID_W'($urandom_range(0, 255));
    start = $urandom_range(0, SLOTS - 1);
    for (k = 0; k < SLOTS; k++) begin
      s = (start + k) % SLOTS;
      if (want_suspended ? task_st[s] == ST_SUSPENDED : task_st[s] != ST_UNUSED)
        return TPID_W'(s);
    end
    return TPID_W'(start);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v)
      note_mismatch($sformatf("%s expected %0d got %0d", name, exp_v, got_v));
  endtask

  // Receiver: stalls on a random pattern when gaps are on; checks each result.
  always @(posedge clk) begin
    outcome_t exp_res;
    if (cycle_count[3:0] == 4'd0)
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    out_ready <= !gaps_on || stall_pat[cycle_count[3:0]];
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        note_mismatch("result with no item pending");
      end else begin
        exp_res = awaited_outcomes.pop_front();
        check_field("status", 8'(exp_res.status), 8'(out_status));
        check_field("result_pid", 8'(exp_res.made_pid), 8'(out_result_pid));
        check_field("running_valid", 8'(exp_res.run_valid), 8'(out_running_valid));
        check_field("running_pid", 8'(exp_res.run_pid), 8'(out_running_pid));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("round_robin_task_scheduler test failed");
      $finish;
    end
  end

  // Ops rejected on an empty table (fork, sleep, exit, suspend, resume), range errors, the undefined op, a tick.
  task automatic test_idle_errors();
    send_item(OP_FORK, 8'd0, 32'd0);
    send_item(OP_SLEEP, 8'd0, 32'd5);
    send_item(OP_EXIT, 8'd0, 32'd0);
    send_item(OP_SUSPEND, 8'd255, 32'd0);
    send_item(OP_SUSPEND, 8'd3, 32'd0);
    send_item(OP_RESUME, 8'd16, 32'd0);
    send_item(OP_UNDEFINED, 8'hAA, 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'd0, 32'd0);
  endtask

  // Fill every slot, then one create too many.
  task automatic test_table_full();
    repeat (SLOTS + 1) send_item(OP_CREATE, 8'd0, 32'd0);
  endtask

  // Sleep with zero count, suspend of the running task, exit and slot reuse.
  task automatic test_task_lifecycle();
    send_item(OP_TICK, 8'd0, 32'd0);
    send_item(OP_SLEEP, 8'd0, 32'd0);
    send_item(OP_TICK, 8'd0, 32'd0);
    send_item(OP_SUSPEND, 8'd2, 32'd0);       // the running one
    send_item(OP_TICK, 8'd0, 32'd0);
    send_item(OP_RESUME, 8'd2, 32'd0);
    send_item(OP_SLEEP, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'd0, 32'd0);
    send_item(OP_EXIT, 8'd0, 32'd0);
    send_item(OP_TICK, 8'd0, 32'd0);
    send_item(OP_FORK, 8'd0, 32'd0);
  endtask

  task automatic test_random_ops(input int count, input bit idling);
    int r;
    logic [OP_W-1:0] op;
    logic [TPID_W-1:0] pid;
    logic [CNT_W-1:0] cnt;
    gaps_on <= idling;
    repeat (count) begin
      r = $urandom_range(0, 99);
      pid = TPID_W'($urandom_range(0, 255));
      cnt = $urandom;
      if (r < 30) op = OP_TICK;
      else if (r < 45) op = OP_CREATE;
      else if (r < 53) op = OP_FORK;
      else if (r < 65) op = OP_SLEEP;
      else if (r < 73) op = OP_EXIT;
      else if (r < 85) op = OP_SUSPEND;
      else if (r < 97) op = OP_RESUME;
      else op = OP_UNDEFINED;
      if (op == OP_SUSPEND) pid = pick_target(1'b0);
      if (op == OP_RESUME) pid = pick_target(1'b1);
      // mostly short sleeps so tasks come back; long ones wait for a resume
      r = $urandom_range(0, 19);
      if (op == OP_SLEEP && r < 12) cnt = CNT_W'($urandom_range(0, 3));
      else if (op == OP_SLEEP && r < 17) cnt = CNT_W'($urandom_range(4, 30));
      send_item(op, pid, cnt);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_errors();
    test_table_full();
    test_task_lifecycle();
    test_random_ops(300, 1'b0);
    test_random_ops(1700, 1'b1);
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("round_robin_task_scheduler test passed");
    else
      $display("round_robin_task_scheduler test failed");
    $finish;
  end

endmodule
